// ----- hw/rtl/rkrf_pkg.sv -----
// Shared types and constants for the RGB 3x3 region filter.
package rkrf_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int CHANNELS = 3;
   localparam int PIX_BITS = SAMPLE_BITS * CHANNELS;
   localparam int WINDOW_TAPS = 9;

   localparam int WIDTH_BITS = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int LEFT_BITS = 11;
   localparam int TOP_BITS = 12;
   localparam int RIGHT_BITS = 12;
   localparam int BOTTOM_BITS = 13;
   localparam int LEVEL_BITS = 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 13;

   localparam int ROW_BITS = 13;
   localparam int COUNT_BITS = 24;
   localparam int POS_BITS = 26;
   localparam int CMP_BITS = 14;

   // Signed kernel sum of one channel and the box blur quotient path.
   localparam int SUM_BITS = 14;
   localparam int BOX_BITS = 12;
   localparam int DIV9_SHIFT = 16;
   localparam int DIV9_MUL = (2 ** DIV9_SHIFT + 8) / 9;
   localparam int DIV9_PROD_BITS = 25;

   typedef logic [PIX_BITS-1:0] pixel_type;

   typedef enum logic [1:0] {
      KERNEL_EDGE    = 2'd0,
      KERNEL_SHARPEN = 2'd1,
      KERNEL_BOX     = 2'd2,
      KERNEL_GAUSS   = 2'd3
   } kernel_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_REGION_LEFT   = 3'd2,
      CSR_REGION_TOP    = 3'd3,
      CSR_REGION_RIGHT  = 3'd4,
      CSR_REGION_BOTTOM = 3'd5,
      CSR_KERNEL_MODE   = 3'd6,
      CSR_MAX_LEVEL     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  image_width;
      logic [HEIGHT_BITS-1:0] image_height;
      logic [LEFT_BITS-1:0]   region_left;
      logic [TOP_BITS-1:0]    region_top;
      logic [RIGHT_BITS-1:0]  region_right;
      logic [BOTTOM_BITS-1:0] region_bottom;
      kernel_type             kernel_mode;
      logic [LEVEL_BITS-1:0]  max_level;
   } cfg_type;

   typedef struct packed {
      pixel_type pixel;
      logic      emit;
      logic      filt;
      logic      last;
   } scan_item_type;

   typedef struct packed {
      logic filt;
      logic last;
   } tap_flags_type;

   typedef struct packed {
      pixel_type pixel;
      logic      last;
   } result_type;

endpackage

// ----- hw/rtl/rkrf_req_if.sv -----
// Input channel: pixel or drain request with valid/ready handshake.
interface rkrf_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
   modport sink (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

// ----- hw/rtl/rkrf_rsp_if.sv -----
// Result channel: finished pixel with valid/ready handshake.
interface rkrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       frame_last;

   modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
   modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ----- hw/rtl/rkrf_ram.sv -----
// Generic single-port-write, registered-read RAM.
module rkrf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/rkrf_scan.sv -----
// Raster position tracking, frame bookkeeping and filter decision per item.
module rkrf_scan #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rkrf_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   input  logic                         in_cmd,
   input  rkrf_pkg::pixel_type          in_pixel,
   input  logic                         take,
   output logic                         in_ready,
   output logic                         push,
   output logic [$clog2(MAX_WIDTH)-1:0] push_idx,
   output rkrf_pkg::scan_item_type      push_item
);
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int RW = rkrf_pkg::ROW_BITS;
   localparam int CW = rkrf_pkg::CMP_BITS;
   localparam int PW = rkrf_pkg::POS_BITS;

   logic [COL_BITS-1:0]                col_ff, col_in;
   logic [RW-1:0]                      row_ff, row_in;
   logic [rkrf_pkg::COUNT_BITS-1:0]    emitted_ff, emitted_in;
   logic [rkrf_pkg::WIDTH_BITS-1:0]    w;
   logic [rkrf_pkg::HEIGHT_BITS-1:0]   h;
   logic                               wrap_now, wrap_next;
   logic [COL_BITS-1:0]                c0;
   logic [RW-1:0]                      r0;
   logic [CW-1:0]                      c_wide, c_next, cm1, rm1;
   logic [PW-1:0]                      pos, total;
   logic                               in_frame, ignore, emit, filt, last, accept;

   always_comb begin
      priority if (cfg.image_width == '0) begin
         w = rkrf_pkg::WIDTH_BITS'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         w = rkrf_pkg::WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w = cfg.image_width;
      end
      h = (cfg.image_height == '0) ? rkrf_pkg::HEIGHT_BITS'(1) : cfg.image_height;

      // A column left past the width by a geometry change wraps to the next row.
      wrap_now = CW'(col_ff) >= CW'(w);
      c0 = wrap_now ? '0 : col_ff;
      r0 = wrap_now ? RW'(row_ff + 1'b1) : row_ff;
      c_wide = CW'(c0);

      pos = PW'(PW'(r0) * PW'(w)) + PW'(c_wide);
      total = PW'(PW'(w) * PW'(h));
      in_frame = pos < total;
      ignore = in_frame && in_cmd;

      c_next = c_wide + CW'(1);
      wrap_next = c_next >= CW'(w);
      emit = pos >= PW'(w) + PW'(1);

      // The window center sits one row up and one column left.
      cm1 = c_wide - CW'(1);
      rm1 = CW'(r0) - CW'(1);
      filt = (CW'(r0) >= CW'(2)) && (c_wide >= CW'(2)) && (CW'(r0) < CW'(h))
         && (c_wide < CW'(w))
         && (cm1 >= CW'(cfg.region_left)) && (cm1 < CW'(cfg.region_right))
         && (rm1 >= CW'(cfg.region_top)) && (rm1 < CW'(cfg.region_bottom));
      last = PW'(emitted_ff) + PW'(1) >= total;

      accept = in_valid && take;
      col_in = col_ff;
      row_in = row_ff;
      emitted_in = emitted_ff;
      if (accept) begin
         priority if (ignore) begin
            col_in = c0;
            row_in = r0;
         end else if (emit && last) begin
            col_in = '0;
            row_in = '0;
            emitted_in = '0;
         end else begin
            col_in = wrap_next ? '0 : c_next[COL_BITS-1:0];
            row_in = wrap_next ? RW'(r0 + 1'b1) : r0;
            if (emit) begin
               emitted_in = emitted_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         emitted_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         emitted_ff <= emitted_in;
      end
   end

   assign in_ready = take;
   assign push = accept && !ignore;
   assign push_idx = c0;
   assign push_item = '{pixel: (in_frame ? in_pixel : '0), emit: emit, filt: filt, last: last};
endmodule

// ----- hw/rtl/rkrf_window.sv -----
// Line stores and the 3x3 window, with read-after-write forwarding.
module rkrf_window #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [$clog2(MAX_WIDTH)-1:0] push_idx,
   input  rkrf_pkg::scan_item_type      push_item,
   input  logic                         take,
   output logic                         in_ready,
   output logic                         win_valid,
   output rkrf_pkg::pixel_type          window [rkrf_pkg::WINDOW_TAPS],
   output rkrf_pkg::tap_flags_type      win_flags
);
   localparam int IDX_BITS = $clog2(MAX_WIDTH);

   logic                    s1_valid_ff, s1_valid_in;
   rkrf_pkg::scan_item_type s1_item_ff, s1_item_in;
   logic [IDX_BITS-1:0]     s1_idx_ff, s1_idx_in;
   logic                    fwd_ff, fwd_in;
   rkrf_pkg::pixel_type     fwd_upper_ff, fwd_upper_in, fwd_middle_ff, fwd_middle_in;
   logic                    s2_valid_ff, s2_valid_in;
   rkrf_pkg::tap_flags_type flags_ff, flags_in;
   rkrf_pkg::pixel_type     win_ff [rkrf_pkg::WINDOW_TAPS];
   rkrf_pkg::pixel_type     win_in [rkrf_pkg::WINDOW_TAPS];
   rkrf_pkg::pixel_type     upper_rd, middle_rd, upper_cur, middle_cur;
   logic                    s1_fire, s2_fire;

   rkrf_ram #(.WIDTH(rkrf_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .wr_en(s1_fire), .wr_addr(s1_idx_ff), .wr_data(middle_cur),
      .rd_en(push), .rd_addr(push_idx), .rd_data(upper_rd)
   );

   rkrf_ram #(.WIDTH(rkrf_pkg::PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .wr_en(s1_fire), .wr_addr(s1_idx_ff), .wr_data(s1_item_ff.pixel),
      .rd_en(push), .rd_addr(push_idx), .rd_data(middle_rd)
   );

   always_comb begin
      s2_fire = s2_valid_ff && take;
      s1_fire = s1_valid_ff && (!s2_valid_ff || s2_fire);
      in_ready = !s1_valid_ff || s1_fire;

      // A one-pixel-wide image reads the entry that the previous item writes.
      upper_cur = fwd_ff ? fwd_upper_ff : upper_rd;
      middle_cur = fwd_ff ? fwd_middle_ff : middle_rd;

      s1_valid_in = push ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_item_in = push ? push_item : s1_item_ff;
      s1_idx_in = push ? push_idx : s1_idx_ff;
      fwd_in = push ? (s1_fire && (s1_idx_ff == push_idx)) : fwd_ff;
      fwd_upper_in = push ? middle_cur : fwd_upper_ff;
      fwd_middle_in = push ? s1_item_ff.pixel : fwd_middle_ff;

      s2_valid_in = s1_fire ? s1_item_ff.emit : (s2_fire ? 1'b0 : s2_valid_ff);
      flags_in = s1_fire
         ? rkrf_pkg::tap_flags_type'{filt: s1_item_ff.filt, last: s1_item_ff.last}
         : flags_ff;

      win_in = win_ff;
      if (s1_fire) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3] = win_ff[k*3+1];
            win_in[k*3+1] = win_ff[k*3+2];
         end
         win_in[2] = upper_cur;
         win_in[5] = middle_cur;
         win_in[8] = s1_item_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
         for (int k = 0; k < rkrf_pkg::WINDOW_TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         fwd_ff <= fwd_in;
         win_ff <= win_in;
      end
      s1_item_ff <= s1_item_in;
      s1_idx_ff <= s1_idx_in;
      fwd_upper_ff <= fwd_upper_in;
      fwd_middle_ff <= fwd_middle_in;
      flags_ff <= flags_in;
   end

   assign win_valid = s2_valid_ff;
   assign window = win_ff;
   assign win_flags = flags_ff;
endmodule

// ----- hw/rtl/rkrf_kernel.sv -----
// Kernel sums, normalization, clamping and the result register.
module rkrf_kernel (
   input  logic                    clock,
   input  logic                    reset,
   input  rkrf_pkg::kernel_type    kernel_mode,
   input  logic [7:0]              max_level,
   input  logic                    in_valid,
   input  rkrf_pkg::pixel_type     window [rkrf_pkg::WINDOW_TAPS],
   input  rkrf_pkg::tap_flags_type in_flags,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rkrf_pkg::result_type    out_result
);
   localparam int SW = rkrf_pkg::SUM_BITS;
   localparam int SB = rkrf_pkg::SAMPLE_BITS;

   logic                    s3_valid_ff, s3_valid_in;
   logic signed [SW-1:0]    sum_ff [rkrf_pkg::CHANNELS];
   logic signed [SW-1:0]    sum_in [rkrf_pkg::CHANNELS];
   rkrf_pkg::pixel_type     center_ff, center_in;
   rkrf_pkg::tap_flags_type flags_ff, flags_in;
   logic                    out_valid_ff, out_valid_in;
   rkrf_pkg::result_type    result_ff, result_in;
   rkrf_pkg::pixel_type     filtered;
   logic signed [SW-1:0]    all9, cross_sum, mid;
   logic                    s3_fire, out_free, in_fire;

   // Rounds box and Gauss sums to their quotient, then clamps one channel sum to 0..max_level.
   function automatic logic [SB-1:0] finish(logic signed [SW-1:0] s,
                                            rkrf_pkg::kernel_type m,
                                            logic [7:0] lim);
      logic signed [SW-1:0]                   v;
      logic [rkrf_pkg::BOX_BITS-1:0]          x;
      logic [rkrf_pkg::DIV9_PROD_BITS-1:0]    prod;
      x = rkrf_pkg::BOX_BITS'(s + SW'(4));
      prod = rkrf_pkg::DIV9_PROD_BITS'(x)
         * rkrf_pkg::DIV9_PROD_BITS'(rkrf_pkg::DIV9_MUL);
      unique case (m)
         rkrf_pkg::KERNEL_EDGE, rkrf_pkg::KERNEL_SHARPEN: v = s;
         rkrf_pkg::KERNEL_BOX:
            v = (s < 0) ? '0 : signed'(SW'(prod >> rkrf_pkg::DIV9_SHIFT));
         rkrf_pkg::KERNEL_GAUSS: v = (s < 0) ? '0 : ((s + SW'(8)) >>> 4);
      endcase
      priority if (v < 0) begin
         finish = '0;
      end else if (v > signed'(SW'(lim))) begin
         finish = SB'(lim);
      end else begin
         finish = v[SB-1:0];
      end
   endfunction

   always_comb begin
      out_free = !out_valid_ff || out_ready;
      s3_fire = s3_valid_ff && out_free;
      in_ready = !s3_valid_ff || s3_fire;
      in_fire = in_valid && in_ready;

      // Every kernel is built from the nine-tap sum, the four-neighbor sum and the center.
      all9 = '0;
      cross_sum = '0;
      mid = '0;
      for (int ch = 0; ch < rkrf_pkg::CHANNELS; ch++) begin
         all9 = '0;
         for (int t = 0; t < rkrf_pkg::WINDOW_TAPS; t++) begin
            all9 = all9 + SW'(window[t][ch*SB +: SB]);
         end
         cross_sum = SW'(window[1][ch*SB +: SB]) + SW'(window[3][ch*SB +: SB])
            + SW'(window[5][ch*SB +: SB]) + SW'(window[7][ch*SB +: SB]);
         mid = SW'(window[4][ch*SB +: SB]);
         unique case (kernel_mode)
            rkrf_pkg::KERNEL_EDGE:    sum_in[ch] = (mid <<< 3) + mid - all9;
            rkrf_pkg::KERNEL_SHARPEN: sum_in[ch] = (mid <<< 2) + mid - cross_sum;
            rkrf_pkg::KERNEL_BOX:     sum_in[ch] = all9;
            rkrf_pkg::KERNEL_GAUSS:   sum_in[ch] = all9 + cross_sum + (mid <<< 1) + mid;
         endcase
         if (!in_fire) begin
            sum_in[ch] = sum_ff[ch];
         end
      end
      center_in = in_fire ? window[4] : center_ff;
      flags_in = in_fire ? in_flags : flags_ff;
      s3_valid_in = in_fire ? 1'b1 : (s3_fire ? 1'b0 : s3_valid_ff);

      for (int ch = 0; ch < rkrf_pkg::CHANNELS; ch++) begin
         filtered[ch*SB +: SB] = finish(sum_ff[ch], kernel_mode, max_level);
      end
      result_in = result_ff;
      if (s3_fire) begin
         result_in = '{pixel: (flags_ff.filt ? filtered : center_ff), last: flags_ff.last};
      end
      out_valid_in = s3_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
      sum_ff <= sum_in;
      center_ff <= center_in;
      flags_ff <= flags_in;
      result_ff <= result_in;
   end

   assign out_valid = out_valid_ff;
   assign out_result = result_ff;
endmodule

// ----- hw/rtl/rgb_kernel3x3_region_filter.sv -----
// Top level of the streaming RGB 3x3 region filter.
//
// Pixels enter on req_bus in raster order, one per transfer; cmd high marks a
// drain item. Inside the frame a drain item is consumed with no effect. Past
// the last pixel every item flushes the window and pushes out one more result,
// so a frame needs image_width + 1 drain items after its pixels to complete.
// Results leave on rsp_bus; frame_last marks the final pixel of the frame,
// after which the position counters restart for the next frame.
// The block takes one item per cycle unless back-pressure stalls its stages. An
// input transfer starts the line store read; the window update, the kernel sum,
// and rounding and clamp into the output register follow as registered stages.
// Each result belongs to the item accepted one row plus one pixel earlier. When
// the receiver stalls, the result register holds and each stage fills in turn;
// req_bus.ready drops once every stage is occupied. Reset clears the position
// counters, window and pipeline valids and loads the register defaults; the line
// stores keep their contents and need no clearing. The user must write registers
// through csr_write_en/csr_index/csr_data only while idle; this is not enforced.
module rgb_kernel3x3_region_filter #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   rkrf_req_if.sink                            req_bus,
   rkrf_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_en,
   input  logic [rkrf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rkrf_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   rkrf_pkg::cfg_type           cfg_ff, cfg_in;
   logic                        scan_take, push, win_valid, kernel_ready;
   logic [$clog2(MAX_WIDTH)-1:0] push_idx;
   rkrf_pkg::scan_item_type     push_item;
   rkrf_pkg::pixel_type         window [rkrf_pkg::WINDOW_TAPS];
   rkrf_pkg::tap_flags_type     win_flags;
   rkrf_pkg::result_type        result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (rkrf_pkg::csr_index_type'(csr_index))
            rkrf_pkg::CSR_IMAGE_WIDTH:
               cfg_in.image_width = csr_data[rkrf_pkg::WIDTH_BITS-1:0];
            rkrf_pkg::CSR_IMAGE_HEIGHT:
               cfg_in.image_height = csr_data[rkrf_pkg::HEIGHT_BITS-1:0];
            rkrf_pkg::CSR_REGION_LEFT:
               cfg_in.region_left = csr_data[rkrf_pkg::LEFT_BITS-1:0];
            rkrf_pkg::CSR_REGION_TOP:
               cfg_in.region_top = csr_data[rkrf_pkg::TOP_BITS-1:0];
            rkrf_pkg::CSR_REGION_RIGHT:
               cfg_in.region_right = csr_data[rkrf_pkg::RIGHT_BITS-1:0];
            rkrf_pkg::CSR_REGION_BOTTOM:
               cfg_in.region_bottom = csr_data[rkrf_pkg::BOTTOM_BITS-1:0];
            rkrf_pkg::CSR_KERNEL_MODE:
               cfg_in.kernel_mode = rkrf_pkg::kernel_type'(csr_data[1:0]);
            rkrf_pkg::CSR_MAX_LEVEL:
               cfg_in.max_level = csr_data[rkrf_pkg::LEVEL_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_width: 12'd1, image_height: 13'd1, region_left: 11'd0,
                     region_top: 12'd0, region_right: 12'd1, region_bottom: 13'd1,
                     kernel_mode: rkrf_pkg::KERNEL_EDGE, max_level: 8'd255};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rkrf_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req_bus.valid), .in_cmd(req_bus.cmd),
      .in_pixel({req_bus.blue_in, req_bus.green_in, req_bus.red_in}),
      .take(scan_take), .in_ready(req_bus.ready),
      .push(push), .push_idx(push_idx), .push_item(push_item)
   );

   rkrf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock(clock), .reset(reset), .push(push), .push_idx(push_idx),
      .push_item(push_item), .take(kernel_ready), .in_ready(scan_take),
      .win_valid(win_valid), .window(window), .win_flags(win_flags)
   );

   rkrf_kernel u_kernel (
      .clock(clock), .reset(reset), .kernel_mode(cfg_ff.kernel_mode),
      .max_level(cfg_ff.max_level), .in_valid(win_valid), .window(window),
      .in_flags(win_flags), .in_ready(kernel_ready),
      .out_valid(rsp_bus.valid), .out_ready(rsp_bus.ready), .out_result(result)
   );

   assign rsp_bus.red_out = result.pixel[7:0];
   assign rsp_bus.green_out = result.pixel[15:8];
   assign rsp_bus.blue_out = result.pixel[23:16];
   assign rsp_bus.frame_last = result.last;
endmodule

// ----- hw/rtl/rkrf_checker.sv -----
// Port-level checks on the result channel, bound to the top level.
module rkrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic       rsp_last
);
   // The result register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Right after reset, no item can yet have crossed the pipeline to the result register.
   a_reset_latency: assert property (@(posedge clock)
      ($past(reset, 1) || $past(reset, 2) || $past(reset, 3)) |-> !rsp_valid)
      else $error("result appeared before pipeline latency");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_last)))
      else $error("result changed while stalled");
endmodule

bind rgb_kernel3x3_region_filter rkrf_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .rsp_red(rsp_bus.red_out), .rsp_green(rsp_bus.green_out),
   .rsp_blue(rsp_bus.blue_out), .rsp_last(rsp_bus.frame_last)
);

// ----- dv/rkrf_checker.sv -----
// Checker for the RGB 3x3 region filter: predicts finished pixels and compares them.
module rkrf_scoreboard (
   input  logic                                clock,
   input  logic                                reset,
   rkrf_req_if                                 req_mon,
   rkrf_rsp_if                                 rsp_mon,
   input  logic                                csr_write_en,
   input  logic [rkrf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rkrf_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  pending_count
);
   localparam int LINE_DEPTH = 2048;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } finished_pixel_type;

   finished_pixel_type expected_pixels[$];

   rkrf_pkg::cfg_type   cfg;
   rkrf_pkg::pixel_type upper_line[LINE_DEPTH];
   rkrf_pkg::pixel_type middle_line[LINE_DEPTH];
   rkrf_pkg::pixel_type window[rkrf_pkg::WINDOW_TAPS];
   int unsigned column_pos, row_pos, emitted;

   function automatic int tap_weight(rkrf_pkg::kernel_type kind, int tap);
      case (kind)
         rkrf_pkg::KERNEL_EDGE:    return (tap == 4) ? 8 : -1;
         rkrf_pkg::KERNEL_SHARPEN: return (tap == 4) ? 5 : ((tap % 2 == 1) ? -1 : 0);
         rkrf_pkg::KERNEL_BOX:     return 1;
         default:                  return (tap == 4) ? 4 : ((tap % 2 == 1) ? 2 : 1);
      endcase
   endfunction

   // Applies the selected kernel to one channel of the current window.
   function automatic logic [7:0] convolve_channel(int chan);
      int sum;
      sum = 0;
      for (int i = 0; i < rkrf_pkg::WINDOW_TAPS; i++)
         sum += tap_weight(cfg.kernel_mode, i) * int'(window[i][chan*8 +: 8]);
      if (cfg.kernel_mode == rkrf_pkg::KERNEL_BOX)
         sum = (sum >= 0) ? (2 * sum + 9) / 18 : 0;
      else if (cfg.kernel_mode == rkrf_pkg::KERNEL_GAUSS)
         sum = (sum >= 0) ? (sum + 8) / 16 : 0;
      if (sum < 0) sum = 0;
      if (sum > int'(cfg.max_level)) sum = int'(cfg.max_level);
      return sum[7:0];
   endfunction

   task automatic advance_scan(logic cmd, rkrf_pkg::pixel_type data_in);
      int unsigned w, h, c, r, idx;
      longint unsigned n, total;
      rkrf_pkg::pixel_type pix;
      logic filt;
      finished_pixel_type res;
      w = cfg.image_width;
      h = cfg.image_height;
      if (w == 0) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (h == 0) h = 1;
      total = longint'(w) * h;
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos++;
      end
      c = column_pos;
      r = row_pos;
      n = longint'(r) * w + c;
      pix = '0;
      if (n < total) begin
         // A drain inside the frame is consumed with no effect.
         if (cmd) return;
         pix = data_in;
      end
      idx = c % LINE_DEPTH;
      for (int k = 0; k < 3; k++) begin
         window[k*3] = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2] = upper_line[idx];
      window[5] = middle_line[idx];
      window[8] = pix;
      upper_line[idx] = middle_line[idx];
      middle_line[idx] = pix;
      column_pos = c + 1;
      if (column_pos >= w) begin
         column_pos = 0;
         row_pos = r + 1;
      end
      if (n < longint'(w) + 1) return;
      filt = (r >= 2) && (c >= 2) && (r < h) && (c < w) &&
             (c - 1 >= cfg.region_left) && (c - 1 < cfg.region_right) &&
             (r - 1 >= cfg.region_top) && (r - 1 < cfg.region_bottom);
      res.red   = filt ? convolve_channel(0) : window[4][7:0];
      res.green = filt ? convolve_channel(1) : window[4][15:8];
      res.blue  = filt ? convolve_channel(2) : window[4][23:16];
      res.last  = (longint'(emitted) + 1 >= total);
      emitted++;
      if (res.last) begin
         column_pos = 0;
         row_pos = 0;
         emitted = 0;
      end
      expected_pixels.push_back(res);
   endtask

   always @(posedge clock) begin
      finished_pixel_type exp_pix;
      if (reset) begin
         cfg.image_width = 12'd1;
         cfg.image_height = 13'd1;
         cfg.region_left = 11'd0;
         cfg.region_top = 12'd0;
         cfg.region_right = 12'd1;
         cfg.region_bottom = 13'd1;
         cfg.kernel_mode = rkrf_pkg::KERNEL_EDGE;
         cfg.max_level = 8'd255;
         for (int i = 0; i < rkrf_pkg::WINDOW_TAPS; i++) window[i] = '0;
         column_pos = 0;
         row_pos = 0;
         emitted = 0;
         expected_pixels.delete();
      end else begin
         // Compare before predicting; a result never belongs to this cycle's input.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result transfer: r=%0d g=%0d b=%0d last=%0b",
                           rsp_mon.red_out, rsp_mon.green_out, rsp_mon.blue_out,
                           rsp_mon.frame_last);
            end else begin
               exp_pix = expected_pixels.pop_front();
               if (rsp_mon.red_out !== exp_pix.red || rsp_mon.green_out !== exp_pix.green ||
                   rsp_mon.blue_out !== exp_pix.blue ||
                   rsp_mon.frame_last !== exp_pix.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"pixel mismatch: expected r=%0d g=%0d b=%0d last=%0b, ",
                               "got r=%0d g=%0d b=%0d last=%0b"},
                              exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.last,
                              rsp_mon.red_out, rsp_mon.green_out, rsp_mon.blue_out,
                              rsp_mon.frame_last);
               end
            end
         end
         if (csr_write_en) begin
            case (rkrf_pkg::csr_index_type'(csr_index))
               rkrf_pkg::CSR_IMAGE_WIDTH:
                  cfg.image_width = csr_data[rkrf_pkg::WIDTH_BITS-1:0];
               rkrf_pkg::CSR_IMAGE_HEIGHT:
                  cfg.image_height = csr_data[rkrf_pkg::HEIGHT_BITS-1:0];
               rkrf_pkg::CSR_REGION_LEFT:
                  cfg.region_left = csr_data[rkrf_pkg::LEFT_BITS-1:0];
               rkrf_pkg::CSR_REGION_TOP:
                  cfg.region_top = csr_data[rkrf_pkg::TOP_BITS-1:0];
               rkrf_pkg::CSR_REGION_RIGHT:
                  cfg.region_right = csr_data[rkrf_pkg::RIGHT_BITS-1:0];
               rkrf_pkg::CSR_REGION_BOTTOM:
                  cfg.region_bottom = csr_data[rkrf_pkg::BOTTOM_BITS-1:0];
               rkrf_pkg::CSR_KERNEL_MODE:
                  cfg.kernel_mode = rkrf_pkg::kernel_type'(csr_data[1:0]);
               default:
                  cfg.max_level = csr_data[rkrf_pkg::LEVEL_BITS-1:0];
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            advance_scan(req_mon.cmd, {req_mon.blue_in, req_mon.green_in, req_mon.red_in});
      end
      pending_count = expected_pixels.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end
endmodule

// ----- dv/rgb_kernel3x3_region_filter_tb.sv -----
// Testbench top for the RGB 3x3 region filter: stimulus, handshake pacing and verdict.
module rgb_kernel3x3_region_filter_tb;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [rkrf_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rkrf_pkg::CSR_DATA_BITS-1:0]  csr_data;
   int fail_count, pending_count;
   int cycle_count = 0;
   int items_sent;
   logic quiet;

   rkrf_req_if req_bus();
   rkrf_rsp_if rsp_bus();

   rgb_kernel3x3_region_filter dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   rkrf_scoreboard checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Neither side inserts random stalls inside this stretch of cycles.
   assign quiet = (cycle_count >= 1000) && (cycle_count < 1600);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL rgb_kernel3x3_region_filter");
         $finish;
      end
   end

   // Receiver: one long hold-off early on, random stalls otherwise.
   initial begin
      int seen;
      rsp_bus.ready = 0;
      seen = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      rsp_bus.ready = 1;
      while (seen < 30) begin
         @(posedge clock);
         if (req_bus.valid && req_bus.ready) seen++;
      end
      @(negedge clock);
      rsp_bus.ready = 0;
      repeat (300) @(negedge clock);
      forever begin
         rsp_bus.ready = quiet || ($urandom_range(99) >= 29);
         @(negedge clock);
      end
   end

   task automatic write_reg(rkrf_pkg::csr_index_type idx, int value);
      csr_write_en = 1;
      csr_index = idx;
      csr_data = value[rkrf_pkg::CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_write_en = 0;
   endtask

   task automatic load_geometry(int w, int h, int left, int top, int right, int bottom,
                                rkrf_pkg::kernel_type kind, int level);
      write_reg(rkrf_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(rkrf_pkg::CSR_IMAGE_HEIGHT, h);
      write_reg(rkrf_pkg::CSR_REGION_LEFT, left);
      write_reg(rkrf_pkg::CSR_REGION_TOP, top);
      write_reg(rkrf_pkg::CSR_REGION_RIGHT, right);
      write_reg(rkrf_pkg::CSR_REGION_BOTTOM, bottom);
      write_reg(rkrf_pkg::CSR_KERNEL_MODE, int'(kind));
      write_reg(rkrf_pkg::CSR_MAX_LEVEL, level);
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while (!quiet && $urandom_range(99) < 29) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.cmd = cmd;
      req_bus.red_in = r;
      req_bus.green_in = g;
      req_bus.blue_in = b;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_sample(int extreme_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < extreme_pct / 2) return 8'd0;
      if (roll < extreme_pct) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   // Sends one whole frame, then the tail that flushes it, and waits until it is out.
   task automatic run_frame(int w, int h, int extreme_pct, int drain_pct);
      int we, he;
      we = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
      he = (h == 0) ? 1 : h;
      for (int i = 0; i < we * he; i++) begin
         if ($urandom_range(99) < drain_pct)
            send_item(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         send_item(1'b0, pick_sample(extreme_pct), pick_sample(extreme_pct),
                   pick_sample(extreme_pct));
      end
      for (int i = 0; i <= we; i++)
         send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      req_bus.valid = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int w, h, frame;
      items_sent = 0;
      reset = 1;
      csr_write_en = 0;
      csr_index = '0;
      csr_data = '0;
      req_bus.valid = 0;
      req_bus.cmd = 0;
      req_bus.red_in = 0;
      req_bus.green_in = 0;
      req_bus.blue_in = 0;
      repeat (10) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // Directed: the default one-pixel frame, then a full edge frame on extreme samples.
      run_frame(1, 1, 100, 0);
      load_geometry(3, 3, 0, 0, 3, 3, rkrf_pkg::KERNEL_EDGE, 255);
      run_frame(3, 3, 100, 20);

      frame = 0;
      while (items_sent < 950 || frame < 12) begin
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 8);
         case (frame)
            0: load_geometry(0, 0, 0, 0, 1, 1, rkrf_pkg::KERNEL_SHARPEN, 255);
            1: load_geometry(6, 5, 0, 0, 2048, 4096, rkrf_pkg::KERNEL_BOX, 255);
            2: load_geometry(6, 5, 0, 0, 6, 5, rkrf_pkg::KERNEL_GAUSS, 0);
            3: load_geometry(7, 6, 4, 4, 2, 2, rkrf_pkg::KERNEL_SHARPEN, 128);
            4: begin
               w = 9; h = 3;
               load_geometry(w, h, 2047, 4095, 2048, 4096, rkrf_pkg::KERNEL_EDGE, 1);
            end
            5: begin
               w = 1; h = 40;
               load_geometry(w, h, 0, 0, 1, 4096, rkrf_pkg::KERNEL_GAUSS, 255);
            end
            6: begin
               w = 40; h = 3;
               load_geometry(w, h, 0, 0, 2048, 3, rkrf_pkg::KERNEL_BOX, 255);
            end
            default: load_geometry(w, h, $urandom_range(0, w), $urandom_range(0, h),
                                   $urandom_range(1, w + 2), $urandom_range(1, h + 2),
                                   rkrf_pkg::kernel_type'($urandom_range(3)),
                                   ($urandom_range(3) == 0) ? $urandom_range(1, 255) : 255);
         endcase
         if (frame < 4) begin
            w = (frame == 0) ? 0 : ((frame == 3) ? 7 : 6);
            h = (frame == 0) ? 0 : ((frame == 3) ? 6 : 5);
         end
         run_frame(w, h, 20, 10);
         frame++;
      end

      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS rgb_kernel3x3_region_filter");
      else
         $display("FAIL rgb_kernel3x3_region_filter");
      $finish;
   end
endmodule
